// ----- rtl/vtp_pkg.sv -----
// Shared types and constants of the vertex transform and projection block.
`default_nettype none
package vtp_pkg;
   localparam int COORD_W = 16;
   localparam int COEF_W  = 16;
   localparam int FRAC_C  = COORD_W - 4;
   localparam int FRAC_K  = COEF_W - 2;
   localparam int ROW_W   = 64;
   localparam int DIST_W  = 16;
   localparam int PROD_W  = COORD_W + COEF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int DEN_W   = COORD_W + 2;
   localparam int NUM_W   = COORD_W + FRAC_C;
   localparam int QUO_W   = COORD_W + 1;
   localparam int MAC_LAT = 3;
   localparam int DIV_LAT = QUO_W + 2;
   localparam int PIPE_LAT = MAC_LAT + DIV_LAT;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROW1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROW2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW3 = 3'd3;
   localparam logic [IDX_W-1:0] REG_DIST = 3'd4;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic signed [COORD_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic signed [COORD_W-1:0] out_w;
      logic signed [COORD_W-1:0] proj_x;
      logic signed [COORD_W-1:0] proj_y;
      logic signed [COORD_W-1:0] proj_z;
      logic                      divide_by_zero;
   } rsp_type;

   // transformed vertex plus denominator state leaving the matrix stages
   typedef struct packed {
      logic signed [3:0][COORD_W-1:0] t;
      logic signed [DEN_W-1:0]        den;
      logic                           zero;
   } xform_type;
endpackage
`default_nettype wire

// ----- rtl/vtp_mac.sv -----
// Matrix multiply stages: products, row sums, shift with saturation, denominator.
`default_nettype none
module vtp_mac (
   input  wire logic                                      clock,
   input  wire logic                                      en,
   input  wire vtp_pkg::req_type                          vin,
   input  wire logic [3:0][vtp_pkg::ROW_W-1:0]            rows,
   input  wire logic signed [vtp_pkg::DIST_W-1:0]         proj_dist,
   output vtp_pkg::xform_type                             xout
);
   logic signed [vtp_pkg::COORD_W-1:0] v [4];
   logic signed [vtp_pkg::PROD_W-1:0]  prod_ff [4][4];
   logic signed [vtp_pkg::SUM_W-1:0]   sum_ff [4];
   logic signed [vtp_pkg::SUM_W-1:0]   shf [4];
   vtp_pkg::xform_type                 x_in, x_ff;

   assign v[0] = vin.in_x;
   assign v[1] = vin.in_y;
   assign v[2] = vin.in_z;
   assign v[3] = vin.in_w;

   // stage 1: sixteen products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               prod_ff[r][c] <= $signed(rows[r][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W])
                                * v[c];
      end
   end

   // stage 2: row sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++)
            sum_ff[r] <= vtp_pkg::SUM_W'(prod_ff[r][0]) + vtp_pkg::SUM_W'(prod_ff[r][1])
                       + vtp_pkg::SUM_W'(prod_ff[r][2]) + vtp_pkg::SUM_W'(prod_ff[r][3]);
      end
   end

   // stage 3: floor shift, saturate, form denominator
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         shf[r] = sum_ff[r] >>> vtp_pkg::FRAC_K;
         if (shf[r] > vtp_pkg::SUM_W'(vtp_pkg::COORD_MAX))
            x_in.t[r] = vtp_pkg::COORD_MAX;
         else if (shf[r] < vtp_pkg::SUM_W'(vtp_pkg::COORD_MIN))
            x_in.t[r] = vtp_pkg::COORD_MIN;
         else
            x_in.t[r] = shf[r][vtp_pkg::COORD_W-1:0];
      end
      x_in.den  = vtp_pkg::DEN_W'($signed(x_in.t[3])) + vtp_pkg::DEN_W'(proj_dist);
      x_in.zero = (x_in.den == '0);
   end

   always_ff @(posedge clock) begin
      if (en)
         x_ff <= x_in;
   end

   assign xout = x_ff;
endmodule
`default_nettype wire

// ----- rtl/vtp_div.sv -----
// One pipelined restoring divider lane, one quotient bit per stage.
`default_nettype none
module vtp_div (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [vtp_pkg::COORD_W-1:0] num,
   input  wire logic signed [vtp_pkg::DEN_W-1:0]   den,
   output logic signed [vtp_pkg::COORD_W-1:0]      quo
);
   localparam int QW = vtp_pkg::QUO_W;

   typedef struct packed {
      logic [QW:0]   rem;
      logic [QW-1:0] q;
      logic [QW-1:0] low;
      logic [QW-1:0] dmag;
      logic          ovf;
      logic          neg;
   } div_stage_type;

   div_stage_type stg_ff [QW+1];
   div_stage_type pre_in;
   logic [vtp_pkg::NUM_W-1:0] nmag;
   logic signed [vtp_pkg::COORD_W-1:0] quo_in, quo_ff;
   logic [QW-1:0] lim;

   // prepare magnitudes and check for overflow
   always_comb begin
      nmag = vtp_pkg::NUM_W'(num[vtp_pkg::COORD_W-1] ? -$signed(vtp_pkg::NUM_W'(num))
                                                     : vtp_pkg::NUM_W'(num))
             << vtp_pkg::FRAC_C;
      pre_in.dmag = den[vtp_pkg::DEN_W-1] ? QW'(-den) : QW'(den);
      pre_in.ovf  = (QW'(nmag >> QW) >= pre_in.dmag);
      pre_in.rem  = (QW+1)'(nmag >> QW);
      pre_in.low  = nmag[QW-1:0];
      pre_in.q    = '0;
      pre_in.neg  = num[vtp_pkg::COORD_W-1] ^ den[vtp_pkg::DEN_W-1];
   end

   always_ff @(posedge clock) begin
      if (en)
         stg_ff[0] <= pre_in;
   end

   // one trial subtraction per stage
   for (genvar k = 1; k <= QW; k++) begin : g_bit
      div_stage_type s_in;
      logic [QW:0]   trial;
      always_comb begin
         s_in  = stg_ff[k-1];
         trial = {stg_ff[k-1].rem[QW-1:0], stg_ff[k-1].low[QW-1]};
         s_in.low = {stg_ff[k-1].low[QW-2:0], 1'b0};
         if (trial >= (QW+1)'(stg_ff[k-1].dmag)) begin
            s_in.rem = trial - (QW+1)'(stg_ff[k-1].dmag);
            s_in.q   = {stg_ff[k-1].q[QW-2:0], 1'b1};
         end else begin
            s_in.rem = trial;
            s_in.q   = {stg_ff[k-1].q[QW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en)
            stg_ff[k] <= s_in;
      end
   end

   // apply sign and saturate
   always_comb begin
      lim = stg_ff[QW].neg ? QW'(1) << (vtp_pkg::COORD_W-1)
                           : QW'(vtp_pkg::COORD_MAX);
      if (stg_ff[QW].ovf || stg_ff[QW].q > lim)
         quo_in = stg_ff[QW].neg ? vtp_pkg::COORD_MIN : vtp_pkg::COORD_MAX;
      else if (stg_ff[QW].neg)
         quo_in = vtp_pkg::COORD_W'(-stg_ff[QW].q);
      else
         quo_in = vtp_pkg::COORD_W'(stg_ff[QW].q);
   end

   always_ff @(posedge clock) begin
      if (en)
         quo_ff <= quo_in;
   end

   assign quo = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/vertex4d_transform_project.sv -----
// Top level: configuration registers, valid pipeline, transform and divider lanes.
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_stall | req_type: in_x..in_w
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type: out_*, proj_*, divide_by_zero
//  csr     | in        | csr_we              | index 0..4, 64-bit data
//
// One vertex per cycle unless a stalled result holds the pipeline; 3 matrix stages, 19 divider stages.
// The divider lanes resolve one quotient bit per stage and set the depth.
// Reset is synchronous; it clears valid bits and loads identity and distance 2.0.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module vertex4d_transform_project (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire vtp_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output vtp_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [vtp_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [vtp_pkg::ROW_W-1:0]      csr_wdata
);
   localparam int LAT = vtp_pkg::PIPE_LAT;
   localparam int DL  = vtp_pkg::DIV_LAT;

   logic [3:0][vtp_pkg::ROW_W-1:0]     rows_ff;
   logic signed [vtp_pkg::DIST_W-1:0]  dist_ff;
   logic [LAT-1:0]                     vld_ff;
   logic                               en;
   vtp_pkg::xform_type                 xf;
   vtp_pkg::xform_type                 aux_ff [DL];
   logic signed [vtp_pkg::COORD_W-1:0] quo [3];

   assign en        = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !en;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++)
            rows_ff[r] <= vtp_pkg::ROW_W'(1) << (r*vtp_pkg::COEF_W + vtp_pkg::FRAC_K);
         dist_ff <= vtp_pkg::DIST_W'(8192);
      end else if (csr_we) begin
         unique case (csr_index)
            vtp_pkg::REG_ROW0: rows_ff[0] <= csr_wdata;
            vtp_pkg::REG_ROW1: rows_ff[1] <= csr_wdata;
            vtp_pkg::REG_ROW2: rows_ff[2] <= csr_wdata;
            vtp_pkg::REG_ROW3: rows_ff[3] <= csr_wdata;
            vtp_pkg::REG_DIST: dist_ff <= csr_wdata[vtp_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end

   vtp_mac u_mac (
      .clock     (clock),
      .en        (en),
      .vin       (req_data),
      .rows      (rows_ff),
      .proj_dist (dist_ff),
      .xout      (xf)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      vtp_div u_div (
         .clock (clock),
         .en    (en),
         .num   (xf.t[c]),
         .den   (xf.den),
         .quo   (quo[c])
      );
   end

   // carry transformed vertex alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         aux_ff[0] <= xf;
         for (int k = 1; k < DL; k++)
            aux_ff[k] <= aux_ff[k-1];
      end
   end

   // assemble the result word
   always_comb begin
      rsp_data.out_x = aux_ff[DL-1].t[0];
      rsp_data.out_y = aux_ff[DL-1].t[1];
      rsp_data.out_z = aux_ff[DL-1].t[2];
      rsp_data.out_w = aux_ff[DL-1].t[3];
      rsp_data.divide_by_zero = aux_ff[DL-1].zero;
      if (aux_ff[DL-1].zero) begin
         rsp_data.proj_x = aux_ff[DL-1].t[0][vtp_pkg::COORD_W-1] ? vtp_pkg::COORD_MIN
                                                                 : vtp_pkg::COORD_MAX;
         rsp_data.proj_y = aux_ff[DL-1].t[1][vtp_pkg::COORD_W-1] ? vtp_pkg::COORD_MIN
                                                                 : vtp_pkg::COORD_MAX;
         rsp_data.proj_z = aux_ff[DL-1].t[2][vtp_pkg::COORD_W-1] ? vtp_pkg::COORD_MIN
                                                                 : vtp_pkg::COORD_MAX;
      end else begin
         rsp_data.proj_x = quo[0];
         rsp_data.proj_y = quo[1];
         rsp_data.proj_z = quo[2];
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

`ifndef SYNTHESIS
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         (rsp_data.proj_x == vtp_pkg::COORD_MAX || rsp_data.proj_x == vtp_pkg::COORD_MIN))
      else $error("zero denominator without saturated projection");
   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.divide_by_zero && rsp_data.out_x == '0 |->
         rsp_data.proj_x == '0)
      else $error("zero numerator gave nonzero quotient");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire
